// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

    // list size and derived widths
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int FCNT_W   = 5;

    // input tdata layout, lowest field first
    localparam int IN_CMD_LSB   = 0;
    localparam int IN_VAL_LSB   = IN_CMD_LSB + CMD_W;
    localparam int IN_LIM_LSB   = IN_VAL_LSB + WORD_W;
    localparam int IN_BITS      = IN_LIM_LSB + LIMIT_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout, lowest field first
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_TAKEN_LSB  = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_RCNT_LSB   = OUT_TAKEN_LSB + WORD_W;
    localparam int OUT_FRONT_LSB  = OUT_RCNT_LSB + FCNT_W;
    localparam int OUT_EMPTY_LSB  = OUT_FRONT_LSB + WORD_W;
    localparam int OUT_ECNT_LSB   = OUT_EMPTY_LSB + 1;
    localparam int OUT_BITS       = OUT_ECNT_LSB + FCNT_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_ONE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_MANY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOMATCH = 2'd3;

    // cell operations
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHL,
        OP_SHR,
        OP_LOAD,
        OP_ROT
    } t_cell_op;

    // control broadcast to every cell
    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   idx;
        logic [WORD_W-1:0]  data;
    } t_cell_ctl;

endpackage

// ===== rtl/bdq_cell.sv =====
module bdq_cell (
    input  logic                        i_clk,
    input  bdq_pkg::t_cell_ctl          i_ctl,
    input  logic [bdq_pkg::IDX_W-1:0]   i_index,
    input  logic [bdq_pkg::WORD_W-1:0]  i_left,
    input  logic [bdq_pkg::WORD_W-1:0]  i_right,
    output logic [bdq_pkg::WORD_W-1:0]  o_data
);
    import bdq_pkg::*;

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic              hit;

    assign hit = (i_index == i_ctl.idx);

    // pick the next word from neighbours or the broadcast
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            OP_HOLD: n_data = r_data;
            OP_SHL:  n_data = i_right;
            OP_SHR:  n_data = i_left;
            OP_LOAD: n_data = hit ? i_ctl.data : r_data;
            OP_ROT:  n_data = hit ? i_ctl.data : i_right;
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/bounded_deque_with_value_delete_core.sv =====
// sequence: a command is captured in idle, then executed; add head, add tail, dequeue, unknown
// codes and deletes that need no scan go straight to done, a scanning delete first steps through
// the L entries; done registers the result once the output is free, so one command at a time,
// and the next transfer is taken once the result is registered, which can wait on back-pressure
// the scan checks one entry per cycle, rotating kept words round to the tail
// reset: control and length cleared, list empty, stored words left undefined
module bounded_deque_with_value_delete_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // command[2:0], value[34:3], remove_limit[50:35], zero fill above
    input  logic [bdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], removed_value[33:2], removed_count[38:34], front_value[70:39],
    // is_empty[71], entry_count[76:72], zero fill above
    output logic [bdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]              r_state,   n_state;
    logic [CNT_W-1:0]        r_len,     n_len;
    logic                    r_m_valid, n_m_valid;
    logic [CMD_W-1:0]        r_cmd,     n_cmd;
    logic [WORD_W-1:0]       r_key,     n_key;
    logic [LIMIT_W-1:0]      r_limit,   n_limit;
    logic [CNT_W-1:0]        r_steps,   n_steps;
    logic [CNT_W-1:0]        r_removed, n_removed;
    logic [STATUS_W-1:0]     r_status,  n_status;
    logic [WORD_W-1:0]       r_taken,   n_taken;
    logic [OUT_TDATA_W-1:0]  r_m_data,  n_m_data;

    t_cell_ctl               cell_ctl;
    logic [WORD_W-1:0]       cell_q [DEPTH];
    logic [CNT_W-1:0]        len_m1;
    logic                    full;
    logic                    head_match;
    logic                    in_xfer;
    logic                    out_free;
    logic [WORD_W-1:0]       front;

    // row of cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = cell_ctl.data;
        end else begin : g_mid_l
            assign left_w = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = cell_ctl.data;
        end else begin : g_mid_r
            assign right_w = cell_q[g+1];
        end
        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_index (IDX_W'(g)),
            .i_left  (left_w),
            .i_right (right_w),
            .o_data  (cell_q[g])
        );
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign len_m1        = r_len - CNT_W'(1);
    assign full          = (r_len == CNT_W'(DEPTH));
    assign head_match    = (cell_q[0] == r_key) && (LIMIT_W'(r_removed) < r_limit);
    assign front         = (r_len != '0) ? cell_q[0] : '0;

    // command sequencer
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_m_valid = r_m_valid;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_limit   = r_limit;
        n_steps   = r_steps;
        n_removed = r_removed;
        n_status  = r_status;
        n_taken   = r_taken;
        n_m_data  = r_m_data;
        cell_ctl.op   = OP_HOLD;
        cell_ctl.idx  = '0;
        cell_ctl.data = r_key;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd     = s_axis_tdata[IN_CMD_LSB +: CMD_W];
                    n_key     = s_axis_tdata[IN_VAL_LSB +: WORD_W];
                    n_limit   = s_axis_tdata[IN_LIM_LSB +: LIMIT_W];
                    n_removed = '0;
                    n_status  = STS_OK;
                    n_taken   = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd) inside
                    CMD_ADD_HEAD: begin
                        if (full) begin
                            n_status = STS_FULL;
                        end else begin
                            cell_ctl.op = OP_SHR;
                            n_len       = r_len + CNT_W'(1);
                        end
                    end
                    CMD_ADD_TAIL: begin
                        if (full) begin
                            n_status = STS_FULL;
                        end else begin
                            cell_ctl.op  = OP_LOAD;
                            cell_ctl.idx = r_len[IDX_W-1:0];
                            n_len        = r_len + CNT_W'(1);
                        end
                    end
                    CMD_DEL_ONE, CMD_DEL_MANY: begin
                        if (r_cmd == CMD_DEL_ONE) begin
                            n_limit = LIMIT_W'(1);
                        end
                        n_steps = r_len;
                        if (r_cmd == CMD_DEL_MANY && r_limit == '0) begin
                            n_status = STS_OK;
                        end else if (r_len == '0) begin
                            n_status = STS_NOMATCH;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_DEQUEUE: begin
                        if (r_len == '0) begin
                            n_status = STS_EMPTY;
                        end else begin
                            cell_ctl.op = OP_SHL;
                            n_taken     = cell_q[0];
                            n_removed   = CNT_W'(1);
                            n_len       = len_m1;
                        end
                    end
                    default: begin
                        n_status = STS_OK;
                    end
                endcase
            end
            S_SCAN: begin
                // head leaves cell 0; kept words re-enter at the tail
                if (head_match) begin
                    cell_ctl.op = OP_SHL;
                    n_len       = len_m1;
                    n_removed   = r_removed + CNT_W'(1);
                end else begin
                    cell_ctl.op   = OP_ROT;
                    cell_ctl.idx  = len_m1[IDX_W-1:0];
                    cell_ctl.data = cell_q[0];
                end
                n_steps = r_steps - CNT_W'(1);
                if (r_steps == CNT_W'(1)) begin
                    n_state = S_DONE;
                    if (n_removed == '0) begin
                        n_status = STS_NOMATCH;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_data = '0;
                    n_m_data[OUT_STATUS_LSB +: STATUS_W] = r_status;
                    n_m_data[OUT_TAKEN_LSB +: WORD_W]    = r_taken;
                    n_m_data[OUT_RCNT_LSB +: FCNT_W]     = FCNT_W'(r_removed);
                    n_m_data[OUT_FRONT_LSB +: WORD_W]    = front;
                    n_m_data[OUT_EMPTY_LSB]              = (r_len == '0);
                    n_m_data[OUT_ECNT_LSB +: FCNT_W]     = FCNT_W'(r_len);
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_m_valid <= n_m_valid;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_limit   <= n_limit;
        r_steps   <= n_steps;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_taken   <= n_taken;
        r_m_data  <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== rtl/bdq_checker.sv =====
module bdq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [bdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bdq_pkg::*;

    logic [STATUS_W-1:0] o_status;
    logic [FCNT_W-1:0]   o_rcnt;
    logic [FCNT_W-1:0]   o_ecnt;
    logic [WORD_W-1:0]   o_taken;
    logic [WORD_W-1:0]   o_front;
    logic                o_empty;

    assign o_status = m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign o_taken  = m_axis_tdata[OUT_TAKEN_LSB +: WORD_W];
    assign o_rcnt   = m_axis_tdata[OUT_RCNT_LSB +: FCNT_W];
    assign o_front  = m_axis_tdata[OUT_FRONT_LSB +: WORD_W];
    assign o_empty  = m_axis_tdata[OUT_EMPTY_LSB];
    assign o_ecnt   = m_axis_tdata[OUT_ECNT_LSB +: FCNT_W];

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // empty flag agrees with the count, and an empty list shows a zero front
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (o_empty == (o_ecnt == '0)) && (!o_empty || o_front == '0))
        else $error("empty flag disagrees with count or front");

    // a failed insert, delete or dequeue removes nothing
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (o_status == STS_FULL || o_status == STS_EMPTY ||
                          o_status == STS_NOMATCH) |-> o_rcnt == '0 && o_taken == '0)
        else $error("failed command reports removal");

    // a dequeue on an empty list leaves it empty
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && o_status == STS_EMPTY |-> o_empty)
        else $error("empty dequeue on non-empty list");

    // no command is taken while a command is in progress
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken during execution");

endmodule

bind bounded_deque_with_value_delete_core bdq_checker u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    // spare command codes above dequeue, which the block must ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_DEQUEUE + 3'd1;
    localparam int SPARE_CODES = (1 << CMD_W) - 1 - CMD_DEQUEUE;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int IDLE_PCT[4]  = '{0, 45, 0, 10};
    localparam int STALL_PCT[4] = '{0, 0, 45, 10};

    // one result transfer, split into its fields
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] removed_value;
        logic [FCNT_W-1:0]        removed_count;
        logic signed [WORD_W-1:0] front_value;
        logic                     is_empty;
        logic [FCNT_W-1:0]        entry_count;
    } t_list_report;

    // list predictor and the reports it still owes
    class deque_tracker;
        logic signed [WORD_W-1:0] held_words[$];
        t_list_report             due_reports[$];
        int                       errors;

        function void apply_command(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] key,
                                    logic [LIMIT_W-1:0] limit);
            t_list_report             r;
            logic signed [WORD_W-1:0] kept[$];
            int                       budget;
            int                       n;
            r = '0;
            n = 0;
            case (cmd) inside
                CMD_ADD_HEAD: begin
                    if (held_words.size() >= DEPTH) r.status = STS_FULL;
                    else held_words.push_front(key);
                end
                CMD_ADD_TAIL: begin
                    if (held_words.size() >= DEPTH) r.status = STS_FULL;
                    else held_words.push_back(key);
                end
                CMD_DEL_ONE, CMD_DEL_MANY: begin
                    // a zero limit on the multi delete does nothing at all
                    if (cmd == CMD_DEL_ONE || limit != 0) begin
                        budget = (cmd == CMD_DEL_ONE) ? 1 : int'(limit);
                        foreach (held_words[i]) begin
                            if (held_words[i] == key && n < budget) n++;
                            else kept.push_back(held_words[i]);
                        end
                        held_words = kept;
                        r.removed_count = FCNT_W'(n);
                        if (n == 0) r.status = STS_NOMATCH;
                    end
                end
                CMD_DEQUEUE: begin
                    if (held_words.size() == 0) begin
                        r.status = STS_EMPTY;
                    end else begin
                        r.removed_value = held_words.pop_front();
                        r.removed_count = FCNT_W'(1);
                    end
                end
                default: ;
            endcase
            r.front_value = (held_words.size() != 0) ? held_words[0] : '0;
            r.is_empty    = (held_words.size() == 0);
            r.entry_count = FCNT_W'(held_words.size());
            due_reports.push_back(r);
        endfunction

        function void flag_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [OUT_TDATA_W-1:0] d);
            t_list_report got;
            t_list_report want;
            got.status        = d[OUT_STATUS_LSB +: STATUS_W];
            got.removed_value = d[OUT_TAKEN_LSB +: WORD_W];
            got.removed_count = d[OUT_RCNT_LSB +: FCNT_W];
            got.front_value   = d[OUT_FRONT_LSB +: WORD_W];
            got.is_empty      = d[OUT_EMPTY_LSB];
            got.entry_count   = d[OUT_ECNT_LSB +: FCNT_W];
            if (due_reports.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %0h", $time, d);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            flag_field("status", WORD_W'(want.status), WORD_W'(got.status));
            flag_field("removed_value", want.removed_value, got.removed_value);
            flag_field("removed_count", WORD_W'(want.removed_count),
                       WORD_W'(got.removed_count));
            flag_field("front_value", want.front_value, got.front_value);
            flag_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
            flag_field("entry_count", WORD_W'(want.entry_count), WORD_W'(got.entry_count));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // command, value, remove_limit, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status, removed_value, removed_count, front_value, is_empty, entry_count, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    deque_tracker tracker;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    logic signed [WORD_W-1:0] key_pool[4];

    bounded_deque_with_value_delete_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // watch both sides for transfers
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tracker.apply_command(s_axis_tdata[IN_CMD_LSB +: CMD_W],
                                  s_axis_tdata[IN_VAL_LSB +: WORD_W],
                                  s_axis_tdata[IN_LIM_LSB +: LIMIT_W]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_report(m_axis_tdata);
    end

    // one command transfer, with random idle cycles ahead of it
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] key,
                            input logic [LIMIT_W-1:0] limit);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_CMD_LSB +: CMD_W]   = cmd;
        d[IN_VAL_LSB +: WORD_W]  = key;
        d[IN_LIM_LSB +: LIMIT_W] = limit;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // random command, biased to grow or to shrink the list
    task automatic send_random(input bit grow);
        logic [CMD_W-1:0]   cmd;
        logic [WORD_W-1:0]  key;
        logic [LIMIT_W-1:0] limit;
        int                 r;
        r = $urandom_range(0, 99);
        if (r >= 98) cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(0, SPARE_CODES - 1));
        else if (grow) begin
            if (r < 35)      cmd = CMD_ADD_HEAD;
            else if (r < 70) cmd = CMD_ADD_TAIL;
            else if (r < 80) cmd = CMD_DEL_ONE;
            else if (r < 88) cmd = CMD_DEL_MANY;
            else             cmd = CMD_DEQUEUE;
        end else begin
            if (r < 15)      cmd = CMD_ADD_HEAD;
            else if (r < 30) cmd = CMD_ADD_TAIL;
            else if (r < 50) cmd = CMD_DEL_ONE;
            else if (r < 65) cmd = CMD_DEL_MANY;
            else             cmd = CMD_DEQUEUE;
        end
        // keys mostly from a small pool so that deletes find matches
        key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 3)] : $urandom;
        r = $urandom_range(0, 9);
        if (r == 0)      limit = '0;
        else if (r <= 5) limit = LIMIT_W'($urandom_range(1, 4));
        else if (r <= 7) limit = LIMIT_W'($urandom_range(5, 20));
        else if (r == 8) limit = '1;
        else             limit = LIMIT_W'($urandom);
        send_cmd(cmd, key, limit);
    endtask

    initial begin
        bit grow;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases and the spare codes
        send_cmd(CMD_DEQUEUE, 32'h1234_5678, 16'h0000);
        send_cmd(CMD_DEL_ONE, 32'h0000_0005, 16'hffff);
        send_cmd(CMD_DEL_MANY, 32'h0000_0005, 16'h0000);
        for (int i = 0; i < SPARE_CODES; i++)
            send_cmd(CMD_SPARE_FIRST + CMD_W'(i), 32'hffff_ffff, 16'hffff);
        // fill to the brim with extremes and repeats of one key
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0: send_cmd(CMD_ADD_TAIL, 32'h0000_0005, 16'h0001);
                1: send_cmd(CMD_ADD_HEAD, 32'h8000_0000, 16'h8000);
                2: send_cmd(CMD_ADD_TAIL, 32'h7fff_ffff, 16'h0000);
                default: send_cmd(CMD_ADD_HEAD, $urandom, 16'h0000);
            endcase
        end
        send_cmd(CMD_ADD_HEAD, 32'h0000_0001, 16'h0000);
        send_cmd(CMD_ADD_TAIL, 32'h0000_0002, 16'h0000);
        // limit above the matches takes them all
        send_cmd(CMD_DEL_MANY, 32'h0000_0005, 16'hffff);
        send_cmd(CMD_DEL_ONE, 32'h7fff_ffff, 16'h0000);
        send_cmd(CMD_DEQUEUE, 32'h0000_0000, 16'h0000);

        // random phases with different idling on both sides
        grow = 1'b1;
        for (int p = 0; p < 4; p++) begin
            src_idle_pct  <= IDLE_PCT[p];
            snk_stall_pct <= STALL_PCT[p];
            key_pool[0] = $urandom;
            key_pool[1] = $urandom_range(0, 7);
            key_pool[2] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            key_pool[3] = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(0, 14) == 0) grow = ~grow;
                send_random(grow);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for a late extra result
        while (tracker.due_reports.size() != 0) @(posedge i_clk);
        repeat (3 + DEPTH + 8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
